[rtl/core/atfb_pkg.sv]
// Shared types and constants of the API transmit frame builder.
package atfb_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [7:0] DELIM_BYTE = 8'h7E;
   localparam logic [7:0] CHECK_BASE = 8'hFF;
   localparam logic [15:0] LENGTH_EXTRA = 16'd5;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_API_KIND = 2'd0;
   localparam logic [1:0] CSR_FRAME_IDENT = 2'd1;
   localparam logic [1:0] CSR_DEST_ADDRESS = 2'd2;
   localparam logic [1:0] CSR_TX_OPTION = 2'd3;

   localparam logic [7:0] RESET_API_KIND = 8'h01;
   localparam logic [7:0] RESET_FRAME_IDENT = 8'h01;
   localparam logic [15:0] RESET_DEST_ADDRESS = 16'h4444;
   localparam logic [7:0] RESET_TX_OPTION = 8'h00;

   // Output positions within one queued item.
   localparam logic [3:0] STEP_DELIM = 4'd0;
   localparam logic [3:0] STEP_LEN_HI = 4'd1;
   localparam logic [3:0] STEP_LEN_LO = 4'd2;
   localparam logic [3:0] STEP_TYPE = 4'd3;
   localparam logic [3:0] STEP_IDENT = 4'd4;
   localparam logic [3:0] STEP_ADDR_HI = 4'd5;
   localparam logic [3:0] STEP_ADDR_LO = 4'd6;
   localparam logic [3:0] STEP_OPTION = 4'd7;
   localparam logic [3:0] STEP_DATA = 4'd8;
   localparam logic [3:0] STEP_CHECK = 4'd9;

   typedef struct packed {
      logic [7:0]  api_kind;
      logic [7:0]  frame_ident;
      logic [15:0] dest_address;
      logic [7:0]  tx_option;
   } cfg_type;

   // One classified item as handed from the front to the back.
   typedef struct packed {
      logic        first;
      logic        last;
      logic [7:0]  data;
      logic [15:0] length;
      cfg_type     hdr;
      logic [7:0]  check;
   } cmd_type;

endpackage

[rtl/core/api_tx16_frame_builder.sv]
// Top level of the API transmit frame builder (16-bit address request).
//
// Payload bytes enter on the req_ queue port: an item is taken at a clock
// edge with req_push high and req_full low. The framed byte stream leaves on
// the rsp_ queue port: the oldest byte is shown while rsp_empty is low and is
// taken at an edge with rsp_pop high. The first byte of a frame produces the
// eight header bytes and then itself; a byte flagged last_byte is followed by
// the checksum byte, which carries rsp_frame_end.
// The first result of an item is shown from the edge after it is taken if the
// output is free. The output side sends one byte per cycle while the receiver
// pops, so a middle payload byte yields one output byte, a frame start nine
// and a last byte one more; a four-item queue between the classifying front
// and the byte sequencer absorbs the header bursts. The csr_ port writes the
// header registers; a write shapes the next frame started after it.
// Reset clears the queue, the output register and the frame state and loads
// the registers with type 0x01, identifier 0x01, address 0x4444, option 0x00.
// When the receiver holds off rsp_pop, the sequencer stalls, the queue fills
// and req_full rises; nothing is lost.
module api_tx16_frame_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_payload_length,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_end,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   atfb_pkg::cfg_type cfg_ff, cfg_in;
   atfb_pkg::cmd_type push_cmd;
   atfb_pkg::cmd_type head_cmd;
   logic q_full, q_empty, q_pop;
   logic accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            atfb_pkg::CSR_API_KIND:     cfg_in.api_kind = csr_wdata[7:0];
            atfb_pkg::CSR_FRAME_IDENT:  cfg_in.frame_ident = csr_wdata[7:0];
            atfb_pkg::CSR_DEST_ADDRESS: cfg_in.dest_address = csr_wdata;
            atfb_pkg::CSR_TX_OPTION:    cfg_in.tx_option = csr_wdata[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
      accept = req_push && !q_full;
      req_full = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.api_kind <= atfb_pkg::RESET_API_KIND;
         cfg_ff.frame_ident <= atfb_pkg::RESET_FRAME_IDENT;
         cfg_ff.dest_address <= atfb_pkg::RESET_DEST_ADDRESS;
         cfg_ff.tx_option <= atfb_pkg::RESET_TX_OPTION;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atfb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .payload_length (req_payload_length),
      .last_byte      (req_last_byte),
      .cfg            (cfg_ff),
      .cmd            (push_cmd)
   );

   atfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   atfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

[rtl/core/atfb_front.sv]
// Front part: classifies items, snapshots the header and keeps the checksum.
module atfb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic [15:0]      payload_length,
   input  logic             last_byte,
   input  atfb_pkg::cfg_type cfg,
   output atfb_pkg::cmd_type cmd
);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] base_check;
   logic [7:0] new_check;

   always_comb begin
      base_check = atfb_pkg::CHECK_BASE - cfg.api_kind - cfg.frame_ident
                   - cfg.dest_address[15:8] - cfg.dest_address[7:0] - cfg.tx_option;
      new_check = (in_frame_ff ? check_ff : base_check) - data_byte;

      cmd.first  = !in_frame_ff;
      cmd.last   = last_byte;
      cmd.data   = data_byte;
      cmd.length = payload_length + atfb_pkg::LENGTH_EXTRA;
      cmd.hdr    = cfg;
      cmd.check  = new_check;

      in_frame_in = in_frame_ff;
      check_in = check_ff;
      if (accept) begin
         in_frame_in = !last_byte;
         check_in = new_check;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         check_ff <= 8'h00;
      end else begin
         in_frame_ff <= in_frame_in;
         check_ff <= check_in;
      end
   end

   // After a last byte is taken, the frame flag must be clear for the next frame start.
   assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> !in_frame_ff)
      else $error("frame flag still set after a last byte");
   assert property (@(posedge clock) disable iff (reset)
      accept && !last_byte |=> in_frame_ff && check_ff == $past(new_check))
      else $error("frame state not carried after a middle byte");
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(in_frame_ff) && $stable(check_ff))
      else $error("frame state changed without an item");

endmodule

[rtl/core/atfb_queue.sv]
// Short queue of classified items between the front and the back.
module atfb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  atfb_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output atfb_pkg::cmd_type head_cmd,
   output logic              empty
);

   atfb_pkg::cmd_type mem_ff [atfb_pkg::QueueDepth];
   logic [atfb_pkg::QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [atfb_pkg::QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [atfb_pkg::QueuePtrWidth:0]   count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      full  = count_ff == (atfb_pkg::QueuePtrWidth+1)'(atfb_pkg::QueueDepth);
      empty = count_ff == '0;
      do_push = push && !full;
      do_pop  = pop && !empty;
      head_cmd = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/core/atfb_back.sv]
// Back part: walks each queued item through its output bytes into the result register.
module atfb_back (
   input  logic              clock,
   input  logic              reset,
   input  atfb_pkg::cmd_type head_cmd,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_frame_end
);

   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_run_last_ff, out_run_last_in;
   logic       out_frame_end_ff, out_frame_end_in;
   logic       advance;
   logic [3:0] cur_step;
   logic       done;

   always_comb begin
      advance = !q_empty && (!out_valid_ff || rsp_pop);
      if (busy_ff) begin
         cur_step = step_ff;
      end else begin
         cur_step = head_cmd.first ? atfb_pkg::STEP_DELIM : atfb_pkg::STEP_DATA;
      end
      done = (cur_step == atfb_pkg::STEP_CHECK)
             || (cur_step == atfb_pkg::STEP_DATA && !head_cmd.last);

      case (cur_step)
         atfb_pkg::STEP_DELIM:   out_byte_in = atfb_pkg::DELIM_BYTE;
         atfb_pkg::STEP_LEN_HI:  out_byte_in = head_cmd.length[15:8];
         atfb_pkg::STEP_LEN_LO:  out_byte_in = head_cmd.length[7:0];
         atfb_pkg::STEP_TYPE:    out_byte_in = head_cmd.hdr.api_kind;
         atfb_pkg::STEP_IDENT:   out_byte_in = head_cmd.hdr.frame_ident;
         atfb_pkg::STEP_ADDR_HI: out_byte_in = head_cmd.hdr.dest_address[15:8];
         atfb_pkg::STEP_ADDR_LO: out_byte_in = head_cmd.hdr.dest_address[7:0];
         atfb_pkg::STEP_OPTION:  out_byte_in = head_cmd.hdr.tx_option;
         atfb_pkg::STEP_DATA:    out_byte_in = head_cmd.data;
         atfb_pkg::STEP_CHECK:   out_byte_in = head_cmd.check;
         default:                out_byte_in = head_cmd.data;
      endcase
      out_run_last_in = (cur_step == atfb_pkg::STEP_CHECK)
                        || (cur_step == atfb_pkg::STEP_DATA && !head_cmd.last);
      out_frame_end_in = cur_step == atfb_pkg::STEP_CHECK;

      q_pop = advance && done;
      busy_in = busy_ff;
      step_in = step_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (advance) begin
         out_valid_in = 1'b1;
         busy_in = !done;
         step_in = cur_step + 4'd1;
      end

      rsp_empty = !out_valid_ff;
      rsp_out_byte = out_byte_ff;
      rsp_run_last = out_run_last_ff;
      rsp_frame_end = out_frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= atfb_pkg::STEP_DELIM;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= out_byte_in;
         out_run_last_ff <= out_run_last_in;
         out_frame_end_ff <= out_frame_end_in;
      end
   end

   // While an item is part-way through, it must still be at the head of the queue.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !q_empty && step_ff != atfb_pkg::STEP_DELIM
                  && step_ff <= atfb_pkg::STEP_CHECK)
      else $error("sequencer busy with no item or a bad step");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_frame_end_ff |-> out_run_last_ff)
      else $error("checksum byte not marked as the item's last result");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff == atfb_pkg::STEP_CHECK |-> head_cmd.last)
      else $error("checksum step reached for an item that is not last");

endmodule

[tb/tb_api_tx16_frame_builder.sv]
// Testbench for the API transmit frame builder: random payload frames checked byte by byte.
`timescale 1ns / 100ps

module tb_api_tx16_frame_builder;

   localparam int RANDOM_ITEMS = 320;
   localparam int HOLD_CYCLES = 150;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_TAIL = 20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } framed_byte_type;

   // Tracks the header registers and the open frame, and holds the bytes still owed.
   class tx_frame_tracker;
      logic [7:0]      api_kind;
      logic [7:0]      frame_ident;
      logic [15:0]     dest_address;
      logic [7:0]      tx_option;
      bit              in_frame;
      logic [7:0]      running_check;
      framed_byte_type framed_q[$];
      int              fails;

      function new();
         api_kind = atfb_pkg::RESET_API_KIND;
         frame_ident = atfb_pkg::RESET_FRAME_IDENT;
         dest_address = atfb_pkg::RESET_DEST_ADDRESS;
         tx_option = atfb_pkg::RESET_TX_OPTION;
         in_frame = 1'b0;
         running_check = 8'h00;
         fails = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            atfb_pkg::CSR_API_KIND: api_kind = value[7:0];
            atfb_pkg::CSR_FRAME_IDENT: frame_ident = value[7:0];
            atfb_pkg::CSR_DEST_ADDRESS: dest_address = value;
            atfb_pkg::CSR_TX_OPTION: tx_option = value[7:0];
            default: ;
         endcase
      endfunction

      function void push_byte(logic [7:0] b, logic run_last, logic frame_end);
         framed_byte_type entry;
         entry.out_byte = b;
         entry.run_last = run_last;
         entry.frame_end = frame_end;
         framed_q.insert(framed_q.size(), entry);
      endfunction

      function void note_item(logic [7:0] data, logic [15:0] plen, logic last);
         logic [15:0] len;
         if (!in_frame) begin
            len = plen + atfb_pkg::LENGTH_EXTRA;
            push_byte(atfb_pkg::DELIM_BYTE, 1'b0, 1'b0);
            push_byte(len[15:8], 1'b0, 1'b0);
            push_byte(len[7:0], 1'b0, 1'b0);
            push_byte(api_kind, 1'b0, 1'b0);
            push_byte(frame_ident, 1'b0, 1'b0);
            push_byte(dest_address[15:8], 1'b0, 1'b0);
            push_byte(dest_address[7:0], 1'b0, 1'b0);
            push_byte(tx_option, 1'b0, 1'b0);
            running_check = atfb_pkg::CHECK_BASE - api_kind - frame_ident
                            - dest_address[15:8] - dest_address[7:0] - tx_option;
            in_frame = 1'b1;
         end
         running_check = running_check - data;
         push_byte(data, !last, 1'b0);
         if (last) begin
            push_byte(running_check, 1'b1, 1'b1);
            in_frame = 1'b0;
         end
      endfunction

      function void check_output(logic [7:0] b, logic run_last, logic frame_end);
         framed_byte_type want;
         if (framed_q.size() == 0) begin
            $display("%0t: out_byte expected none, actual %02h", $time, b);
            fails++;
            return;
         end
         want = framed_q.pop_front();
         if (b !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, actual %02h", $time, want.out_byte, b);
            fails++;
         end
         if (run_last !== want.run_last) begin
            $display("%0t: run_last expected %0b, actual %0b", $time, want.run_last, run_last);
            fails++;
         end
         if (frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b, actual %0b", $time, want.frame_end,
                     frame_end);
            fails++;
         end
      endfunction

      function int pending();
         return framed_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic [15:0] req_payload_length = 16'h0000;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_frame_end;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = atfb_pkg::CSR_API_KIND;
   logic [15:0] csr_wdata = 16'h0000;

   tx_frame_tracker tracker;
   int  push_run = 0;
   int  pop_run = 0;
   int  frame_left = 0;
   bit  hold_req = 1'b0;

   api_tx16_frame_builder dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data_byte(req_data_byte),
      .req_payload_length(req_payload_length),
      .req_last_byte(req_last_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .rsp_frame_end(rsp_frame_end),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly random gaps, with occasional runs of back-to-back items.
   function automatic int draw_gap(inout int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         run = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   task automatic send_item(input logic [7:0] data, input logic [15:0] plen, input logic last);
      int gap;
      gap = draw_gap(push_run);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= data;
      req_payload_length <= plen;
      req_last_byte <= last;
      do @(posedge clock); while (req_full);
      tracker.note_item(data, plen, last);
   endtask

   task automatic send_random_item();
      logic [15:0] plen;
      if (frame_left == 0)
         frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      // The length only matters on a frame's first byte; it is usually the true count.
      case ($urandom_range(0, 9))
         0: plen = 16'($urandom);
         1: plen = 16'h0000;
         2: plen = 16'hFFFF;
         3: plen = 16'd65530;
         default: plen = 16'(frame_left);
      endcase
      send_item(8'($urandom), plen, frame_left == 1);
      frame_left--;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_header(input logic [7:0] ftype, input logic [7:0] ident,
                               input logic [15:0] addr, input logic [7:0] option);
      write_reg(atfb_pkg::CSR_API_KIND, {8'h00, ftype});
      write_reg(atfb_pkg::CSR_FRAME_IDENT, {8'h00, ident});
      write_reg(atfb_pkg::CSR_DEST_ADDRESS, addr);
      write_reg(atfb_pkg::CSR_TX_OPTION, {8'h00, option});
   endtask

   function automatic logic [15:0] draw_reg_value();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_random_regs();
      if ($urandom_range(0, 2) != 0) write_reg(atfb_pkg::CSR_API_KIND, draw_reg_value());
      if ($urandom_range(0, 2) != 0) write_reg(atfb_pkg::CSR_FRAME_IDENT, draw_reg_value());
      if ($urandom_range(0, 2) != 0) write_reg(atfb_pkg::CSR_DEST_ADDRESS, draw_reg_value());
      if ($urandom_range(0, 2) != 0) write_reg(atfb_pkg::CSR_TX_OPTION, draw_reg_value());
   endtask

   // Stops offering items and waits until every owed byte has come out.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int phase;
      int phase_len;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset header values: a one-byte frame, a frame whose length field disagrees with
      // its byte count, a length that wraps, and a zero length that leaves a frame open.
      send_item(8'h00, 16'd1, 1'b1);
      send_item(8'hFF, 16'd65530, 1'b0);
      send_item(8'hA5, 16'hFFFF, 1'b0);
      send_item(8'h5A, 16'h0000, 1'b1);
      send_item(8'h3C, 16'hFFFF, 1'b1);
      send_item(8'h81, 16'h0000, 1'b0);
      send_item(8'h7E, 16'h0000, 1'b0);
      wait_drained();

      // The open frame must finish with the old header values in its checksum.
      write_header(8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      send_item(8'h01, 16'h1234, 1'b1);
      send_item(8'hC3, 16'd65531, 1'b1);
      send_item(8'h55, 16'd2, 1'b0);
      send_item(8'hAA, 16'd2, 1'b1);
      wait_drained();

      write_header(8'h00, 8'h00, 16'h0000, 8'h00);
      send_item(8'hFF, 16'd1, 1'b1);
      send_item(8'h00, 16'd3, 1'b0);
      send_item(8'h00, 16'h0000, 1'b0);
      send_item(8'hFF, 16'h0000, 1'b1);
      wait_drained();
      write_header(8'h10, 8'h80, 16'h8001, 8'h04);

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(15, 50);
         if (phase == 1 || phase == 4)
            hold_req = 1'b1;
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            send_random_item();
            sent++;
         end
         wait_drained();
         write_random_regs();
         phase++;
      end

      repeat (DRAIN_TAIL) @(posedge clock);
      if (tracker.fails == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Output side: random pop gaps, and now and then a long hold-off so the input backs up.
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            gap = HOLD_CYCLES;
         end else begin
            gap = draw_gap(pop_run);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         tracker.check_output(rsp_out_byte, rsp_run_last, rsp_frame_end);
      end
   end

   initial begin
      int stall;
      stall = 0;
      do @(posedge clock); while (reset);
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall = 0;
         else
            stall++;
      end
      $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
rtl/core/atfb_pkg.sv
rtl/core/atfb_front.sv
rtl/core/atfb_queue.sv
rtl/core/atfb_back.sv
rtl/core/api_tx16_frame_builder.sv
tb/tb_api_tx16_frame_builder.sv
